/* hw/rtl/interval_set_range_tracker_macros.svh */
// ----------------------------------------------------------------------------
// Interval set range tracker assertion macros
// Shorthand for the concurrent checks that the tracker's controller carries.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_RANGE_TRACKER_MACROS_SVH
`define INTERVAL_SET_RANGE_TRACKER_MACROS_SVH

// Condition in one cycle implies a condition in the next cycle.
`define ISRT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (pre) |=> (post)) else $error("isrt check failed");

// Condition implies another condition in the same cycle.
`define ISRT_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (pre) |-> (post)) else $error("isrt check failed");

`endif

/* hw/rtl/isrt_pkg.sv */
// ----------------------------------------------------------------------------
// Interval set range tracker package
// Shared codes, widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package isrt_pkg;

    localparam int POS_W = 30;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_code_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_wr;   // write a sentinel entry into bank zero
        logic init_one;  // which sentinel: 0 = position zero, 1 = limit
        logic load;      // capture the incoming word
        logic rd;        // read the next old table entry
        logic proc;      // consume the entry read last cycle
        logic finish;    // form the result and commit the new table
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;      // invalid span or unused command, no table pass
        logic last;      // every old entry has been consumed
    } dp_stat_t;

endpackage

/* hw/rtl/isrt_datapath.sv */
// ----------------------------------------------------------------------------
// Interval set range tracker datapath
// Ping-pong breakpoint table memory and the per-entry merge and query logic.
// ----------------------------------------------------------------------------
module isrt_datapath #(
    parameter int TABLE_DEPTH    = 64,
    parameter int POSITION_LIMIT = 1000000000
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                in_command,
    input  logic [isrt_pkg::POS_W-1:0] in_left_edge,
    input  logic [isrt_pkg::POS_W-1:0] in_right_edge,
    input  isrt_pkg::ctrl_cmd_t       cmd_i,
    output isrt_pkg::dp_stat_t        stat_o,
    output logic                      res_covered,
    output logic                      res_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = $clog2(TABLE_DEPTH + 3);
    localparam int MD = 2 ** (AW + 1);
    localparam int PW = isrt_pkg::POS_W;

    // Each entry is {position, covered}. Bank bit is the top address bit.
    logic [PW:0]   mem [0:MD-1];
    logic [PW:0]   rd_data_reg;

    logic          bank_reg;
    logic [CW-1:0] count_reg;
    isrt_pkg::cmd_code_t cmd_reg;
    logic [PW-1:0] l_reg;
    logic [PW-1:0] r_reg;
    logic          valid_reg;
    logic [CW-1:0] k_reg;
    logic [WW-1:0] wcnt_reg;
    logic [1:0]    need_reg;
    logic          l_done_reg;
    logic          r_done_reg;
    logic          cov_reg;
    logic [PW-1:0] prev_pos_reg;
    logic          prev_cov_reg;
    logic          fail_reg;
    logic          res_covered_reg;
    logic          res_status_reg;

    logic [PW-1:0] p;
    logic          c;
    logic          is_mod;
    logic          adv, emit, ins, set_l, set_r;
    logic [PW-1:0] epos;
    logic          ecov;
    logic          we;
    logic [AW:0]   waddr;
    logic [PW:0]   wdata;
    logic          full;
    logic          span_ok;

    assign p      = rd_data_reg[PW:1];
    assign c      = rd_data_reg[0];
    assign is_mod = (cmd_reg == isrt_pkg::CMD_ADD) || (cmd_reg == isrt_pkg::CMD_REMOVE);
    assign full   = (WW'(count_reg) + WW'(need_reg)) > WW'(TABLE_DEPTH);
    assign span_ok = (in_left_edge != '0) && (in_left_edge < in_right_edge) &&
                     (in_right_edge <= PW'(POSITION_LIMIT));

    assign stat_o.skip = !valid_reg || (cmd_reg == isrt_pkg::CMD_RSVD);
    assign stat_o.last = (k_reg == count_reg);
    assign res_covered = res_covered_reg;
    assign res_status  = res_status_reg;

    // Merge step: old entries below the span are copied, the left edge is
    // written with the new coverage, entries inside the span are dropped and
    // the right edge keeps the coverage that held just before it.
    always_comb begin
        adv   = 1'b1;
        emit  = 1'b0;
        ins   = 1'b0;
        set_l = 1'b0;
        set_r = 1'b0;
        epos  = p;
        ecov  = c;
        if (is_mod) begin
            if (!l_done_reg) begin
                emit = 1'b1;
                if (p == l_reg) begin
                    ecov  = (cmd_reg == isrt_pkg::CMD_ADD);
                    set_l = 1'b1;
                end else if (p > l_reg) begin
                    epos  = l_reg;
                    ecov  = (cmd_reg == isrt_pkg::CMD_ADD);
                    set_l = 1'b1;
                    adv   = 1'b0;
                    ins   = 1'b1;
                end
            end else if (!r_done_reg) begin
                if (p == r_reg) begin
                    emit  = 1'b1;
                    set_r = 1'b1;
                end else if (p > r_reg) begin
                    emit  = 1'b1;
                    epos  = r_reg;
                    ecov  = cov_reg;
                    set_r = 1'b1;
                    adv   = 1'b0;
                    ins   = 1'b1;
                end
            end else begin
                emit = 1'b1;
            end
        end
    end

    always_comb begin
        if (cmd_i.init_wr) begin
            we    = 1'b1;
            waddr = {1'b0, (cmd_i.init_one ? AW'(1) : AW'(0))};
            wdata = cmd_i.init_one ? {PW'(POSITION_LIMIT), 1'b0} : '0;
        end else begin
            we    = cmd_i.proc && emit && (wcnt_reg < WW'(TABLE_DEPTH));
            waddr = {~bank_reg, wcnt_reg[AW-1:0]};
            wdata = {epos, ecov};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd_i.rd) begin
            rd_data_reg <= mem[{bank_reg, k_reg[AW-1:0]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg  <= 1'b0;
            count_reg <= CW'(2);
        end else if (cmd_i.finish && is_mod && valid_reg && !full) begin
            bank_reg  <= ~bank_reg;
            count_reg <= wcnt_reg[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            cmd_reg    <= isrt_pkg::cmd_code_t'(in_command);
            l_reg      <= in_left_edge;
            r_reg      <= in_right_edge;
            valid_reg  <= span_ok;
            k_reg      <= '0;
            wcnt_reg   <= '0;
            need_reg   <= '0;
            l_done_reg <= 1'b0;
            r_done_reg <= 1'b0;
            cov_reg    <= 1'b0;
            fail_reg   <= 1'b0;
        end else if (cmd_i.proc) begin
            if (emit) begin
                wcnt_reg <= wcnt_reg + WW'(1);
            end
            if (ins) begin
                need_reg <= need_reg + 2'd1;
            end
            if (set_l) begin
                l_done_reg <= 1'b1;
            end
            if (set_r) begin
                r_done_reg <= 1'b1;
            end
            if (adv) begin
                k_reg        <= k_reg + CW'(1);
                prev_pos_reg <= p;
                prev_cov_reg <= c;
                if (p < r_reg) begin
                    cov_reg <= c;
                end
                // The segment ending here overlaps the span and is uncovered.
                if ((k_reg != '0) && (prev_pos_reg < r_reg) && (p > l_reg) &&
                    !prev_cov_reg) begin
                    fail_reg <= 1'b1;
                end
            end
        end
        if (cmd_i.finish) begin
            res_covered_reg <= (cmd_reg == isrt_pkg::CMD_QUERY) && valid_reg && !fail_reg;
            res_status_reg  <= is_mod && valid_reg && full;
        end
    end

endmodule

/* hw/rtl/isrt_ctrl.sv */
// ----------------------------------------------------------------------------
// Interval set range tracker controller
// Sequences the table init, the per-entry read/merge pass and the handshakes.
// ----------------------------------------------------------------------------
`include "interval_set_range_tracker_macros.svh"

module isrt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output isrt_pkg::ctrl_cmd_t  cmd_o,
    input  isrt_pkg::dp_stat_t   stat_i
);

    typedef enum logic [6:0] {
        ST_INIT0  = 7'b0000001,
        ST_INIT1  = 7'b0000010,
        ST_IDLE   = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_RD     = 7'b0010000,
        ST_PROC   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_o          = '0;
        unique case (state_reg)
            ST_INIT0: begin
                cmd_o.init_wr = 1'b1;
                state_next    = ST_INIT1;
            end
            ST_INIT1: begin
                cmd_o.init_wr  = 1'b1;
                cmd_o.init_one = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = stat_i.skip ? ST_FINISH : ST_RD;
            end
            ST_RD: begin
                if (stat_i.last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd_o.rd   = 1'b1;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                cmd_o.proc = 1'b1;
                state_next = ST_RD;
            end
            ST_FINISH: begin
                if (slot_free) begin
                    cmd_o.finish = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT0;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd_o.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `ISRT_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, state_reg == ST_CHECK)
    `ISRT_ASSERT_NEXT(a_finish_shows, cmd_o.finish, m_tvalid_reg)
    `ISRT_ASSERT_NEXT(a_proc_returns, state_reg == ST_PROC, state_reg == ST_RD)
    `ISRT_ASSERT_SAME(a_finish_no_clobber, cmd_o.finish, !m_tvalid_reg || m_tready)

endmodule

/* hw/rtl/interval_set_range_tracker.sv */
// ----------------------------------------------------------------------------
// Interval set range tracker
// Keeps a set of covered half-open spans as a sorted breakpoint table.
// ----------------------------------------------------------------------------
// Usage: one word on the s_ channel is a command (add, remove or query) on
// the span [left_edge, right_edge). Each accepted word yields exactly one
// word on the m_ channel carrying covered (query answer) and status (set when
// an add or remove was dropped because the table would overflow).
// Invalid spans and the unused command code raise m_tvalid with zeros
// after the states ST_CHECK and ST_FINISH, with no table pass. A valid
// command makes one pass over the current table, reading each entry and,
// for an add or remove, merging it into the other memory bank; an inserted
// edge costs one more such step. Each entry takes a registered read of the
// table memory (state ST_RD) followed by the merge or query check of that
// entry (state ST_PROC); one command is worked on at a time.
// Reset: aresetn is synchronous and active low. After it the block writes
// the sentinel breakpoints at zero and at the limit (states ST_INIT0 and
// ST_INIT1), with s_tready low, then accepts commands.
// Stall: the result sits in an output register; while the receiver holds
// m_tready low the next command may still be accepted and processed, and
// its result waits until the output register is free.
// ----------------------------------------------------------------------------
module interval_set_range_tracker #(
    parameter int TABLE_DEPTH    = 64,
    parameter int POSITION_LIMIT = 1000000000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [31:2] left_edge, [61:32] right_edge, [63:62] zero
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] covered, [1] status, [7:2] zero
    output logic [7:0]  m_tdata
);

    isrt_pkg::ctrl_cmd_t cmd;
    isrt_pkg::dp_stat_t  stat;
    logic                res_covered;
    logic                res_status;

    // The controller owns both handshakes; the datapath owns the table.
    isrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd_o    (cmd),
        .stat_i   (stat)
    );

    isrt_datapath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .POSITION_LIMIT (POSITION_LIMIT)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_command    (s_tdata[1:0]),
        .in_left_edge  (s_tdata[31:2]),
        .in_right_edge (s_tdata[61:32]),
        .cmd_i         (cmd),
        .stat_o        (stat),
        .res_covered   (res_covered),
        .res_status    (res_status)
    );

    // Result fields are held in the datapath's output registers.
    assign m_tdata = {6'b000000, res_status, res_covered};

endmodule

/* bench/interval_set_range_tracker_test.sv */
// ----------------------------------------------------------------------------
// Interval set range tracker testbench
// Drives add, remove and query words with random idling on both channels and
// checks every answer against a breakpoint-table predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module interval_set_range_tracker_test;

    localparam int DEPTH     = 64;
    localparam int LIMIT     = 1000000000;
    localparam int MAX_CYCLE = 2000000;

    typedef struct packed {
        isrt_pkg::cmd_code_t       cmd;
        logic [isrt_pkg::POS_W-1:0] lft;
        logic [isrt_pkg::POS_W-1:0] rgt;
    } span_word_t;

    typedef struct packed {
        logic covered;
        logic status;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    span_word_t  pending_words[$];
    answer_t     awaited_answers[$];
    int          errors = 0;
    int          cycle = 0;
    bit          calm = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;

    // Predictor copy of the breakpoint table.
    logic [31:0] bp_pos[DEPTH];
    logic        bp_cov[DEPTH];
    logic [31:0] bp_len[DEPTH];
    int          bp_count;

    always #5 aclk = ~aclk;

    interval_set_range_tracker #(
        .TABLE_DEPTH(DEPTH),
        .POSITION_LIMIT(LIMIT)
    ) i_dut (.*);

    function automatic int first_at_or_above(logic [31:0] p);
        for (int i = 0; i < bp_count; i++)
            if (bp_pos[i] >= p) return i;
        return bp_count;
    endfunction

    function automatic bit holds_edge(logic [31:0] p);
        int i;
        i = first_at_or_above(p);
        return i < bp_count && bp_pos[i] == p;
    endfunction

    function automatic logic [31:0] length_before(logic [31:0] p);
        int i;
        int j;
        i = first_at_or_above(p);
        j = (i == 0) ? 0 : i - 1;
        return bp_len[j] + (bp_cov[j] ? p - bp_pos[j] : 32'd0);
    endfunction

    function automatic void add_edge(logic [31:0] p);
        int i;
        i = first_at_or_above(p);
        if (i < bp_count && bp_pos[i] == p) return;
        if (i == 0 || bp_count >= DEPTH) return;
        for (int k = bp_count; k > i; k--) begin
            bp_pos[k] = bp_pos[k-1];
            bp_cov[k] = bp_cov[k-1];
            bp_len[k] = bp_len[k-1];
        end
        bp_pos[i] = p;
        bp_cov[i] = bp_cov[i-1];
        bp_len[i] = bp_len[i-1] + (bp_cov[i-1] ? p - bp_pos[i-1] : 32'd0);
        bp_count++;
    endfunction

    function automatic void paint_span(logic [31:0] l, logic [31:0] r, logic v);
        int il;
        int ir;
        int gap;
        il = first_at_or_above(l);
        if (il >= bp_count) return;
        bp_cov[il] = v;
        ir = first_at_or_above(r);
        if (ir > il + 1) begin
            gap = ir - (il + 1);
            for (int k = ir; k < bp_count; k++) begin
                bp_pos[k-gap] = bp_pos[k];
                bp_cov[k-gap] = bp_cov[k];
                bp_len[k-gap] = bp_len[k];
            end
            bp_count -= gap;
        end
        for (int k = il + 1; k < bp_count; k++)
            bp_len[k] = bp_len[k-1] + (bp_cov[k-1] ? bp_pos[k] - bp_pos[k-1] : 32'd0);
    endfunction

    // Applies one command to the table copy and returns the awaited answer.
    function automatic answer_t apply_span_command(span_word_t w);
        answer_t     a;
        logic [31:0] l;
        logic [31:0] r;
        int          need;
        a = '0;
        l = {2'b00, w.lft};
        r = {2'b00, w.rgt};
        if (w.cmd == isrt_pkg::CMD_RSVD || l < 1 || l >= r || r > LIMIT) return a;
        if (w.cmd == isrt_pkg::CMD_QUERY) begin
            a.covered = (length_before(r) - length_before(l)) == (r - l);
            return a;
        end
        need = (holds_edge(l) ? 0 : 1) + (holds_edge(r) ? 0 : 1);
        if (bp_count + need > DEPTH) begin
            a.status = 1'b1;
            return a;
        end
        add_edge(l);
        add_edge(r);
        paint_span(l, r, w.cmd == isrt_pkg::CMD_ADD);
        return a;
    endfunction

    function automatic span_word_t make_word(isrt_pkg::cmd_code_t c, int l, int r);
        span_word_t w;
        w.cmd = c;
        w.lft = l[isrt_pkg::POS_W-1:0];
        w.rgt = r[isrt_pkg::POS_W-1:0];
        return w;
    endfunction

    // Appends one word to the stimulus queue.
    function automatic void queue_word(span_word_t w);
        pending_words = {pending_words, w};
    endfunction

    // Random spans: mostly valid, with positions from a small grid so that
    // edges coincide, sometimes anywhere on the line, rarely malformed.
    function automatic span_word_t random_word();
        int l;
        int r;
        int pick;
        isrt_pkg::cmd_code_t c;
        pick = $urandom_range(0, 99);
        c = isrt_pkg::cmd_code_t'(pick < 35 ? isrt_pkg::CMD_ADD :
                                  pick < 60 ? isrt_pkg::CMD_REMOVE :
                                  pick < 97 ? isrt_pkg::CMD_QUERY : isrt_pkg::CMD_RSVD);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            l = $urandom_range(1, 40) * 1000;
            r = l + $urandom_range(1, 12) * 1000;
        end else if (pick < 90) begin
            l = $urandom_range(1, LIMIT - 1);
            r = $urandom_range(l + 1, LIMIT);
        end else begin
            l = $urandom & 32'h3FFF_FFFF;
            r = $urandom & 32'h3FFF_FFFF;
        end
        return make_word(c, l, r);
    endfunction

    initial begin
        int base;
        // The predictor table starts with sentinels at zero and at the limit.
        for (int i = 0; i < DEPTH; i++) begin
            bp_pos[i] = '0;
            bp_cov[i] = 1'b0;
            bp_len[i] = '0;
        end
        bp_pos[1] = LIMIT;
        bp_count  = 2;
        // Directed: extremes, every command, malformed spans and table fill.
        queue_word(make_word(isrt_pkg::CMD_QUERY, 1, LIMIT));
        queue_word(make_word(isrt_pkg::CMD_ADD, 1, LIMIT));
        queue_word(make_word(isrt_pkg::CMD_QUERY, 1, LIMIT));
        queue_word(make_word(isrt_pkg::CMD_QUERY, LIMIT - 1, LIMIT));
        queue_word(make_word(isrt_pkg::CMD_REMOVE, 500, 600));
        queue_word(make_word(isrt_pkg::CMD_QUERY, 499, 501));
        queue_word(make_word(isrt_pkg::CMD_QUERY, 600, 700));
        queue_word(make_word(isrt_pkg::CMD_ADD, 0, 10));
        queue_word(make_word(isrt_pkg::CMD_ADD, 20, 20));
        queue_word(make_word(isrt_pkg::CMD_REMOVE, 30, 10));
        queue_word(make_word(isrt_pkg::CMD_QUERY, 5, LIMIT + 1));
        queue_word(make_word(isrt_pkg::CMD_RSVD, 1, 2));
        queue_word(make_word(isrt_pkg::CMD_QUERY, 32'h3FFF_FFFF, 32'h3FFF_FFFF));
        queue_word(make_word(isrt_pkg::CMD_REMOVE, 1, LIMIT));
        // Many disjoint adds and removes fill the table until commands are dropped.
        for (int i = 0; i < 36; i++) begin
            base = 1000 + i * 10;
            queue_word(make_word(i % 3 == 2 ? isrt_pkg::CMD_REMOVE : isrt_pkg::CMD_ADD,
                                 base, base + 5));
        end
        queue_word(make_word(isrt_pkg::CMD_QUERY, 1000, 1005));
        queue_word(make_word(isrt_pkg::CMD_REMOVE, 1, LIMIT));
        for (int i = 0; i < 600; i++) begin
            if (i % 150 == 149) queue_word(make_word(isrt_pkg::CMD_REMOVE, 1, LIMIT));
            queue_word(random_word());
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver.
    always @(posedge aclk) begin
        span_word_t w;
        cycle <= cycle + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                w = pending_words.pop_front();
                awaited_answers = {awaited_answers, apply_span_command(w)};
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_words.size() > 0) begin
                    if (send_gap > 0) begin
                        send_gap <= send_gap - 1;
                        s_tvalid <= 1'b0;
                    end else if (!calm && $urandom_range(0, 5) == 0) begin
                        send_gap <= $urandom_range(0, 7);
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata <= {2'b00, pending_words[0].rgt, pending_words[0].lft,
                                    pending_words[0].cmd};
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            calm <= pending_words.size() < 60;
        end
    end

    // Monitor with random receiver stalls.
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        int      bad;
        bad = 0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.covered = m_tdata[0];
                got.status = m_tdata[1];
                if (awaited_answers.size() == 0) begin
                    $display("%0t: unexpected answer %b", $time, m_tdata);
                    bad++;
                end else begin
                    want = awaited_answers.pop_front();
                    if (got.covered !== want.covered) begin
                        $display("%0t: covered expected %b actual %b", $time,
                                 want.covered, got.covered);
                        bad++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %b actual %b", $time,
                                 want.status, got.status);
                        bad++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $display("%0t: padding expected 0 actual %h", $time, m_tdata[7:2]);
                        bad++;
                    end
                end
            end
            if (bad != 0) begin
                errors <= errors + bad;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (aresetn);
        while ((pending_words.size() > 0 || s_tvalid || awaited_answers.size() > 0)
               && cycle < MAX_CYCLE)
            @(posedge aclk);
        if (cycle >= MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            repeat (200) @(posedge aclk);
            if (errors == 0 && awaited_answers.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

/* interval_set_range_tracker.f */
+incdir+hw/rtl
hw/rtl/isrt_pkg.sv
hw/rtl/isrt_datapath.sv
hw/rtl/isrt_ctrl.sv
hw/rtl/interval_set_range_tracker.sv
bench/interval_set_range_tracker_test.sv
